// ===== rtl/hre_pkg.sv =====
// Shared types and constants for the nested rhythm element.
// Used by hre_level and hyper_euclidean_rhythm_element; depends on nothing.
package hre_pkg;

   localparam int CFG_BITS   = 8;
   localparam int REG_LEVELS = 3;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_SPAN            = 3'd0;
   localparam logic [2:0] REG_PULSES_FIRST    = 3'd1;
   localparam logic [2:0] REG_PULSES_SECOND   = 3'd2;
   localparam logic [2:0] REG_PULSES_THIRD    = 3'd3;
   localparam logic [2:0] REG_ROTATION_FIRST  = 3'd4;
   localparam logic [2:0] REG_ROTATION_SECOND = 3'd5;
   localparam logic [2:0] REG_ROTATION_THIRD  = 3'd6;
   localparam logic [2:0] REG_LEVELS_IN_USE   = 3'd7;

   localparam logic [CFG_BITS-1:0] RST_SPAN          = 8'd16;
   localparam logic [CFG_BITS-1:0] RST_PULSES_FIRST  = 8'd5;
   localparam logic [CFG_BITS-1:0] RST_PULSES_SECOND = 8'd3;
   localparam logic [CFG_BITS-1:0] RST_PULSES_THIRD  = 8'd2;
   localparam logic [1:0]          RST_LEVELS        = 2'd1;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ORDER     = 2'd1;
   localparam logic [1:0] ERR_POSITION  = 2'd2;

   // Settings of one level as seen by its pipeline.
   typedef struct packed {
      logic [CFG_BITS-1:0] span;
      logic [CFG_BITS-1:0] pulses;
      logic [CFG_BITS-1:0] rotation;
      logic                active;
   } level_cfg_type;

endpackage

// ===== rtl/hyper_euclidean_rhythm_element.sv =====
// Nested rhythm element: for each position returns the composed set element,
// one item accepted per clock while rsp_stall does not hold the pipeline. It
// builds L = min(MAX_LEVELS, 3) levels on W = min(VALUE_BITS, 8) bit values;
// each level runs three bit-per-cell divider chains in a row. Settings must
// be written while no item is in flight. Depends on hre_pkg and hre_level.
module hyper_euclidean_rhythm_element #(
   parameter int MAX_LEVELS = 3,
   parameter int VALUE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_position,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_element,
   output logic [1:0] rsp_error_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int W  = (VALUE_BITS < hre_pkg::CFG_BITS) ? VALUE_BITS : hre_pkg::CFG_BITS;
   localparam int NL = (MAX_LEVELS < hre_pkg::REG_LEVELS) ? MAX_LEVELS : hre_pkg::REG_LEVELS;

   logic [W-1:0] count_ff [4];
   logic [W-1:0] rot_ff   [3];
   logic [1:0]   levels_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= hre_pkg::RST_SPAN[W-1:0];
         count_ff[1] <= hre_pkg::RST_PULSES_FIRST[W-1:0];
         count_ff[2] <= hre_pkg::RST_PULSES_SECOND[W-1:0];
         count_ff[3] <= hre_pkg::RST_PULSES_THIRD[W-1:0];
         rot_ff[0]   <= '0;
         rot_ff[1]   <= '0;
         rot_ff[2]   <= '0;
         levels_ff   <= hre_pkg::RST_LEVELS;
      end else if (csr_valid) begin
         unique case (csr_index)
            hre_pkg::REG_SPAN:            count_ff[0] <= csr_data[W-1:0];
            hre_pkg::REG_PULSES_FIRST:    count_ff[1] <= csr_data[W-1:0];
            hre_pkg::REG_PULSES_SECOND:   count_ff[2] <= csr_data[W-1:0];
            hre_pkg::REG_PULSES_THIRD:    count_ff[3] <= csr_data[W-1:0];
            hre_pkg::REG_ROTATION_FIRST:  rot_ff[0]   <= csr_data[W-1:0];
            hre_pkg::REG_ROTATION_SECOND: rot_ff[1]   <= csr_data[W-1:0];
            hre_pkg::REG_ROTATION_THIRD:  rot_ff[2]   <= csr_data[W-1:0];
            hre_pkg::REG_LEVELS_IN_USE:   levels_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Effective depth: zero counts as one, and it saturates at the built levels.
   logic [1:0] depth;
   always_comb begin
      if (levels_ff == 2'd0) begin
         depth = 2'd1;
      end else if (levels_ff > 2'(NL)) begin
         depth = 2'(NL);
      end else begin
         depth = levels_ff;
      end
   end

   logic [W-1:0] pos_w;
   logic         order_bad;
   logic [1:0]   err_in;

   assign pos_w = req_position[W-1:0];

   always_comb begin
      order_bad = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if ((2'(j) < depth) && (count_ff[j] <= count_ff[j+1])) begin
            order_bad = 1'b1;
         end
      end
   end

   always_comb begin
      priority if (order_bad) begin
         err_in = hre_pkg::ERR_ORDER;
      end else if (pos_w >= count_ff[depth]) begin
         err_in = hre_pkg::ERR_POSITION;
      end else begin
         err_in = hre_pkg::ERR_NONE;
      end
   end

   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   logic         in_valid_ff;
   logic [W-1:0] in_x_ff;
   logic [1:0]   in_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_x_ff   <= pos_w;
         in_err_ff <= err_in;
      end
   end

   // The deepest level comes first in the chain.
   logic         lv_valid [NL+1];
   logic [W-1:0] lv_x     [NL+1];
   logic [1:0]   lv_err   [NL+1];

   assign lv_valid[NL] = in_valid_ff;
   assign lv_x[NL]     = in_x_ff;
   assign lv_err[NL]   = in_err_ff;

   for (genvar k = 0; k < NL; k++) begin : g_level
      hre_pkg::level_cfg_type cfg;

      assign cfg = '{span:     8'(count_ff[k]),
                     pulses:   8'(count_ff[k+1]),
                     rotation: 8'(rot_ff[k]),
                     active:   (2'(k) < depth)};

      hre_level #(.W(W), .SIDE_BITS(2)) u_level (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cfg      (cfg),
         .in_valid (lv_valid[k+1]),
         .in_x     (lv_x[k+1]),
         .in_side  (lv_err[k+1]),
         .out_valid(lv_valid[k]),
         .out_x    (lv_x[k]),
         .out_side (lv_err[k])
      );
   end

   logic [7:0] element_ff;
   logic [1:0] error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lv_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         element_ff <= (lv_err[0] == hre_pkg::ERR_NONE) ? 8'(lv_x[0]) : 8'd0;
         error_ff   <= lv_err[0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_element    = element_ff;
   assign rsp_error_code = error_ff;

endmodule

// ===== rtl/hre_cell.sv =====
// One restoring division step with a pipeline register.
// Standalone; chained by hre_div.
module hre_cell #(
   parameter int NUM_BITS  = 8,
   parameter int DEN_BITS  = 8,
   parameter int SIDE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DEN_BITS-1:0]  den,
   input  logic                 in_valid,
   input  logic [DEN_BITS-1:0]  in_rem,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [DEN_BITS-1:0]  out_rem,
   output logic [NUM_BITS-1:0]  out_num,
   output logic [SIDE_BITS-1:0] out_side
);

   logic [DEN_BITS:0]    trial;
   logic [DEN_BITS:0]    diff;
   logic                 ge;
   logic                 valid_ff;
   logic [DEN_BITS-1:0]  rem_ff,  rem_in;
   logic [NUM_BITS-1:0]  num_ff,  num_in;
   logic [SIDE_BITS-1:0] side_ff;

   assign trial  = {in_rem, in_num[NUM_BITS-1]};
   assign ge     = trial >= {1'b0, den};
   assign diff   = trial - {1'b0, den};
   assign rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
   // The numerator shifts out at the top while quotient bits enter at the bottom.
   assign num_in = {in_num[NUM_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/hre_div.sv =====
// Pipelined divider: a chain of hre_cell, one quotient bit per cell.
// Depends on hre_cell.
module hre_div #(
   parameter int NUM_BITS  = 8,
   parameter int DEN_BITS  = 8,
   parameter int SIDE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DEN_BITS-1:0]  den,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [NUM_BITS-1:0]  out_quot,
   output logic [DEN_BITS-1:0]  out_rem,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 valid [NUM_BITS+1];
   logic [DEN_BITS-1:0]  rem   [NUM_BITS+1];
   logic [NUM_BITS-1:0]  num   [NUM_BITS+1];
   logic [SIDE_BITS-1:0] side  [NUM_BITS+1];

   assign valid[0] = in_valid;
   assign rem[0]   = '0;
   assign num[0]   = in_num;
   assign side[0]  = in_side;

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
      hre_cell #(
         .NUM_BITS (NUM_BITS),
         .DEN_BITS (DEN_BITS),
         .SIDE_BITS(SIDE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .den      (den),
         .in_valid (valid[k]),
         .in_rem   (rem[k]),
         .in_num   (num[k]),
         .in_side  (side[k]),
         .out_valid(valid[k+1]),
         .out_rem  (rem[k+1]),
         .out_num  (num[k+1]),
         .out_side (side[k+1])
      );
   end

   assign out_valid = valid[NUM_BITS];
   assign out_quot  = num[NUM_BITS];
   assign out_rem   = rem[NUM_BITS];
   assign out_side  = side[NUM_BITS];

endmodule

// ===== rtl/hre_level.sv =====
// One level of the nested set: maps an index to an entry of the rotated set,
// or passes it through when inactive. Depends on hre_pkg and hre_div.
module hre_level #(
   parameter int W         = 8,
   parameter int SIDE_BITS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  hre_pkg::level_cfg_type cfg,
   input  logic                  in_valid,
   input  logic [W-1:0]          in_x,
   input  logic [SIDE_BITS-1:0]  in_side,
   output logic                  out_valid,
   output logic [W-1:0]          out_x,
   output logic [SIDE_BITS-1:0]  out_side
);

   localparam int W2 = 2 * W;
   localparam int SX = SIDE_BITS + W;
   localparam int SR = SX + W;
   localparam int SC = SR + 1;

   logic [W-1:0] s, p, r;
   assign s = cfg.span[W-1:0];
   assign p = cfg.pulses[W-1:0];
   assign r = cfg.rotation[W-1:0];

   // Rotation reduced modulo the span.
   logic          a_valid;
   logic [W-1:0]  a_rem;
   logic [SX-1:0] a_side;

   hre_div #(.NUM_BITS(W), .DEN_BITS(W), .SIDE_BITS(SX)) u_div_rot (
      .clock(clock), .reset(reset), .advance(advance), .den(s),
      .in_valid(in_valid), .in_num(r), .in_side({in_side, in_x}),
      .out_valid(a_valid), .out_quot(), .out_rem(a_rem), .out_side(a_side)
   );

   // Numerator of the wrap threshold, ceil((s - rr) * p / s).
   logic          m1_valid_ff;
   logic [W2-1:0] m1_num_ff, m1_num_in;
   logic [SR-1:0] m1_side_ff;
   logic [W-1:0]  m_val;

   assign m_val     = s - a_rem;
   assign m1_num_in = W2'(m_val) * W2'(p) + W2'(s) - W2'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_num_ff  <= m1_num_in;
         m1_side_ff <= {a_side, a_rem};
      end
   end

   logic          b_valid;
   logic [W2-1:0] b_quot;
   logic [SR-1:0] b_side;

   hre_div #(.NUM_BITS(W2), .DEN_BITS(W), .SIDE_BITS(SR)) u_div_thr (
      .clock(clock), .reset(reset), .advance(advance), .den(s),
      .in_valid(m1_valid_ff), .in_num(m1_num_ff), .in_side(m1_side_ff),
      .out_valid(b_valid), .out_quot(b_quot), .out_rem(), .out_side(b_side)
   );

   // Count of wrapping entries and the index into the unrotated set.
   logic [W-1:0]  b_x, b_rr, c_val, n_in;
   logic          wrap_in;
   logic          c_valid_ff;
   logic [W-1:0]  n_ff;
   logic [SC-1:0] c_side_ff;

   assign b_rr    = b_side[W-1:0];
   assign b_x     = b_side[W2-1:W];
   assign c_val   = (b_quot <= W2'(p)) ? (p - b_quot[W-1:0]) : '0;
   assign wrap_in = b_x < c_val;
   assign n_in    = wrap_in ? (p - c_val + b_x) : (b_x - c_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff      <= n_in;
         c_side_ff <= {b_side, wrap_in};
      end
   end

   logic          m2_valid_ff;
   logic [W2-1:0] m2_prod_ff;
   logic [SC-1:0] m2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_prod_ff <= W2'(n_ff) * W2'(s);
         m2_side_ff <= c_side_ff;
      end
   end

   logic          q_valid;
   logic [W2-1:0] q_quot;
   logic [SC-1:0] q_side;

   hre_div #(.NUM_BITS(W2), .DEN_BITS(W), .SIDE_BITS(SC)) u_div_entry (
      .clock(clock), .reset(reset), .advance(advance), .den(p),
      .in_valid(m2_valid_ff), .in_num(m2_prod_ff), .in_side(m2_side_ff),
      .out_valid(q_valid), .out_quot(q_quot), .out_rem(), .out_side(q_side)
   );

   // Wrapped entries fall back below the span.
   logic                 q_wrap;
   logic [W-1:0]         q_rr, q_x, res_in;
   logic                 valid_ff;
   logic [W-1:0]         x_ff;
   logic [SIDE_BITS-1:0] side_ff;

   assign q_wrap = q_side[0];
   assign q_rr   = q_side[W:1];
   assign q_x    = q_side[W2:W+1];
   assign res_in = cfg.active ? (q_quot[W-1:0] + q_rr - (q_wrap ? s : '0)) : q_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= res_in;
         side_ff <= q_side[SC-1:W2+1];
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_side  = side_ff;

endmodule
